// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, operation codes, keyword table and types for the RPN
// stack script interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int TOKEN_MAX_DEF   = 31;
  localparam int WORD_W          = 32;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  // operation codes
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd6;
  localparam logic [OP_W-1:0] OP_CHAR  = 4'd7;
  localparam logic [OP_W-1:0] OP_DUP   = 4'd8;
  localparam logic [OP_W-1:0] OP_DROP  = 4'd9;
  localparam logic [OP_W-1:0] OP_SWAP  = 4'd10;
  localparam logic [OP_W-1:0] OP_EXIT  = 4'd11;

  // output kinds
  localparam logic KIND_PRINT = 1'b0;
  localparam logic KIND_CHAR  = 1'b1;

  // keyword table, earlier entries win
  localparam int KW_N      = 10;
  localparam int KW_MAXLEN = 8;

  localparam logic [7:0] KW_STR [KW_N][KW_MAXLEN] = '{
    '{8'h2b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // +
    '{8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // -
    '{8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // *
    '{8'h2f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // /
    '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},  // print
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},  // char
    '{8'h64, 8'h75, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // dup
    '{8'h64, 8'h72, 8'h6f, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // drop
    '{8'h73, 8'h77, 8'h61, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // swap
    '{8'h65, 8'h78, 8'h69, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00}   // exit
  };

  localparam int KW_LEN [KW_N] = '{1, 1, 1, 1, 5, 4, 3, 4, 4, 4};

  localparam logic [OP_W-1:0] KW_OP [KW_N] = '{
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PRINT,
    OP_CHAR, OP_DUP, OP_DROP, OP_SWAP, OP_EXIT
  };

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] value;
  } tok_info_t;

endpackage

`default_nettype wire

// ===== rtl/rpn_if.sv =====
// ----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels for script bytes in and emitted values out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_script;

  modport source (output valid, output data_byte, output end_of_script, input ready);
  modport sink   (input valid, input data_byte, input end_of_script, output ready);
endinterface

interface rpn_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [31:0] out_value;

  modport source (output valid, output out_kind, output out_value, input ready);
  modport sink   (input valid, input out_kind, input out_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpn_tok.sv =====
// ----------------------------------------------------------------------------
// rpn_tok
// Token tracker: follows the kept characters of the current token and keeps
// the decimal value and keyword matches up to date, one character a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_tok
  import rpn_pkg::*;
#(
  parameter int TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       clear,
  input  wire logic       push_en,
  input  wire logic [7:0] ch,
  output tok_info_t       info
);

  localparam int LW = $clog2(TOKEN_MAX + 1);

  logic [LW-1:0]     len;
  logic              first_dig;
  logic              first_dash;
  logic              second_dig;
  logic              run;
  logic [WORD_W-1:0] acc;
  logic [KW_N-1:0]   kw_ok;

  logic              dig;
  logic [WORD_W-1:0] dval;
  logic              is_num;

  assign dig  = ch inside {[CH_0:CH_9]};
  assign dval = WORD_W'(ch - CH_0) & WORD_W'(4'hf);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len        <= '0;
      first_dig  <= 1'b0;
      first_dash <= 1'b0;
      second_dig <= 1'b0;
      run        <= 1'b0;
      kw_ok      <= '1;
    end else if (push_en && (len != LW'(TOKEN_MAX))) begin
      len <= len + LW'(1);
      for (int k = 0; k < KW_N; k++) begin
        if ((int'(len) >= KW_LEN[k]) || (ch != KW_STR[k][len[2:0]]))
          kw_ok[k] <= 1'b0;
      end
      if (len == '0) begin
        first_dig  <= dig;
        first_dash <= (ch == CH_DASH);
        run        <= dig || (ch == CH_DASH);
        acc        <= dig ? dval : '0;
      end else begin
        if (len == LW'(1))
          second_dig <= dig;
        if (run && dig)
          acc <= (acc << 3) + (acc << 1) + dval;
        else
          run <= 1'b0;
      end
    end
  end

  assign is_num = first_dig || (first_dash && second_dig);

  always_comb begin
    info.value = first_dash ? (WORD_W'(0) - acc) : acc;
    info.op    = OP_NONE;
    if (len != '0) begin
      if (is_num) begin
        info.op = OP_PUSH;
      end else begin
        for (int k = KW_N - 1; k >= 0; k--) begin
          if (kw_ok[k] && (int'(len) == KW_LEN[k]))
            info.op = KW_OP[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, truncating toward zero. Restoring, one quotient bit
// a cycle on the magnitudes, sign applied at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div
  import rpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      quotient
);

  localparam int CW = $clog2(WORD_W);

  logic              active;
  logic [CW-1:0]     cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] mb;
  logic              neg;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        quo    <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
        mb     <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
        neg    <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (active) begin
        if (!diff[WORD_W]) begin
          rem <= diff[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WORD_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (WORD_W'(0) - quo) : quo;

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_script_interpreter.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_script_interpreter
// Byte-serial RPN script interpreter with a memory-held value stack.
// ----------------------------------------------------------------------------
// A byte inside a token is taken straight away. A byte that ends a token
// (space, tab, newline, or the last byte of the script) holds the input
// through the decode and execute states while the token is decoded, the two
// top stack entries are read from the stack memory and the operation is
// carried out; multiply and swap add a write-back state, and divide runs the
// 32-step iterative divider before its write-back. print and char also wait
// while an earlier value is not yet taken. The last byte of a script clears
// the stack count, the token and the halt flag once its token is done.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_script_interpreter
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int TOKEN_MAX   = TOKEN_MAX_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  localparam int W  = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  logic [2:0]        state;
  logic [W-1:0]      sc;
  logic              halted;
  logic              last_pend;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] push_val;
  logic [WORD_W-1:0] res;
  logic [AW-1:0]     wb_addr;
  logic [WORD_W-1:0] rd_top;
  logic [WORD_W-1:0] rd_sec;
  logic              out_valid;
  logic              out_kind;
  logic [WORD_W-1:0] out_value;

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

  logic              accept;
  logic              is_sep;
  logic              tok_push;
  logic              tok_clear;
  tok_info_t         tok_info;
  logic [W-1:0]      sc_m1;
  logic [W-1:0]      sc_m2;
  logic              has1;
  logic              has2;
  logic              room;
  logic              out_busy;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;
  logic [WORD_W-1:0] prod;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_sep      = in_ch.data_byte inside {CH_SPACE, CH_TAB, CH_NL};
  assign tok_push    = accept && !halted && !is_sep;
  assign tok_clear   = (state == S_DEC) || (accept && halted && in_ch.end_of_script);

  assign sc_m1    = sc - W'(1);
  assign sc_m2    = sc - W'(2);
  assign has1     = (sc != '0);
  assign has2     = (sc >= W'(2));
  assign room     = (sc < W'(STACK_DEPTH));
  assign out_busy = out_valid && !out_ch.ready;
  assign prod     = rd_sec * rd_top;

  rpn_tok #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_tok (
    .clk     (clk),
    .rst     (rst),
    .clear   (tok_clear),
    .push_en (tok_push),
    .ch      (in_ch.data_byte),
    .info    (tok_info)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_sec),
    .divisor  (rd_top),
    .done     (div_done),
    .quotient (div_q)
  );

  // stack memory write port and divider start
  always_comb begin
    we        = 1'b0;
    waddr     = sc[AW-1:0];
    wdata     = push_val;
    div_start = 1'b0;
    if (state == S_EXE) begin
      case (op)
        OP_PUSH: begin
          we    = room;
          waddr = sc[AW-1:0];
          wdata = push_val;
        end
        OP_ADD: begin
          we    = has2;
          waddr = sc_m2[AW-1:0];
          wdata = rd_sec + rd_top;
        end
        OP_SUB: begin
          we    = has2;
          waddr = sc_m2[AW-1:0];
          wdata = rd_sec - rd_top;
        end
        OP_DUP: begin
          we    = has1 && room;
          waddr = sc[AW-1:0];
          wdata = rd_top;
        end
        OP_SWAP: begin
          we    = has2;
          waddr = sc_m1[AW-1:0];
          wdata = rd_sec;
        end
        OP_DIV: begin
          div_start = has2 && (rd_top != '0);
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (state == S_WB) begin
      we    = 1'b1;
      waddr = wb_addr;
      wdata = res;
    end
  end

  always_ff @(posedge clk) begin
    if (we)
      stack_mem[waddr] <= wdata;
    rd_top <= stack_mem[sc_m1[AW-1:0]];
    rd_sec <= stack_mem[sc_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sc        <= '0;
      halted    <= 1'b0;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (halted) begin
              if (in_ch.end_of_script) begin
                sc     <= '0;
                halted <= 1'b0;
              end
            end else if (is_sep || in_ch.end_of_script) begin
              last_pend <= in_ch.end_of_script;
              state     <= S_DEC;
            end
          end
        end
        S_DEC: begin
          op       <= tok_info.op;
          push_val <= tok_info.value;
          state    <= S_EXE;
        end
        S_EXE: begin
          state <= S_IDLE;
          case (op)
            OP_PUSH: if (room) sc <= sc + W'(1);
            OP_ADD:  if (has2) sc <= sc_m1;
            OP_SUB:  if (has2) sc <= sc_m1;
            OP_MUL: begin
              if (has2) begin
                res     <= prod;
                wb_addr <= sc_m2[AW-1:0];
                sc      <= sc_m1;
                state   <= S_WB;
              end
            end
            OP_DIV: if (has2 && (rd_top != '0)) state <= S_DIV;
            OP_PRINT, OP_CHAR: begin
              if (has1) begin
                if (out_busy) begin
                  state <= S_EXE;
                end else begin
                  out_valid <= 1'b1;
                  out_kind  <= (op == OP_CHAR) ? KIND_CHAR : KIND_PRINT;
                  out_value <= (op == OP_CHAR) ? (rd_top & WORD_W'(8'hff)) : rd_top;
                  sc        <= sc_m1;
                end
              end
            end
            OP_DUP:  if (has1 && room) sc <= sc + W'(1);
            OP_DROP: if (has1) sc <= sc_m1;
            OP_SWAP: begin
              if (has2) begin
                res     <= rd_top;
                wb_addr <= sc_m2[AW-1:0];
                state   <= S_WB;
              end
            end
            OP_EXIT: halted <= 1'b1;
            default: state <= S_IDLE;
          endcase
          // end of script: drop everything once this token is settled
          if (last_pend && !(op == OP_MUL && has2) && !(op == OP_SWAP && has2)
              && !(op == OP_DIV && has2 && (rd_top != '0))
              && !((op == OP_PRINT || op == OP_CHAR) && has1 && out_busy)) begin
            sc     <= '0;
            halted <= 1'b0;
          end
        end
        S_WB: begin
          state <= S_IDLE;
          if (last_pend) begin
            sc     <= '0;
            halted <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res     <= div_q;
            wb_addr <= sc_m2[AW-1:0];
            sc      <= sc_m1;
            state   <= S_WB;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_kind  = out_kind;
  assign out_ch.out_value = out_value;

endmodule

`default_nettype wire

// ===== tb/sv/rpn_stack_script_interpreter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_script_interpreter_test
// Drives scripts into the interpreter byte by byte and checks every emitted
// value against a behavioural stack machine kept in the testbench.
// ----------------------------------------------------------------------------

module rpn_stack_script_interpreter_test;
  import rpn_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int TMAX  = TOKEN_MAX_DEF;

  typedef struct {
    logic [7:0] data_byte;
    logic       last;
  } script_byte_t;

  typedef struct {
    logic        kind;
    logic [31:0] value;
  } emitted_t;

  logic clk;
  logic rst;

  rpn_in_if  in_ch ();
  rpn_out_if out_ch ();

  rpn_stack_script_interpreter DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  script_byte_t pending_bytes[$];
  emitted_t     expected_values[$];
  int           error_count;
  int           emitted_count;
  int           bytes_sent;
  bit           stimulus_done;
  bit           calm;
  int           hold_off;
  bit           in_fire;

  // predictor state
  logic [7:0]  tok_buf[TMAX];
  int          tok_len;
  logic [31:0] vstack[DEPTH];
  int          vcount;
  bit          halted;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit token_matches(string w);
    if (tok_len != w.len()) return 0;
    for (int i = 0; i < w.len(); i++)
      if (tok_buf[i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic bit close_token(output emitted_t res);
    bit          hit;
    int          i;
    logic [31:0] v;
    hit = 0;
    if (tok_len == 0) return 0;
    if (is_digit(tok_buf[0]) ||
        (tok_buf[0] == CH_DASH && tok_len >= 2 && is_digit(tok_buf[1]))) begin
      i = (tok_buf[0] == CH_DASH) ? 1 : 0;
      v = '0;
      while (i < tok_len && is_digit(tok_buf[i])) begin
        v = v * 32'd10 + 32'(tok_buf[i] - CH_0);
        i++;
      end
      if (tok_buf[0] == CH_DASH) v = -v;
      if (vcount < DEPTH) begin
        vstack[vcount] = v;
        vcount++;
      end
    end else if (token_matches("+")) begin
      if (vcount >= 2) begin vstack[vcount-2] += vstack[vcount-1]; vcount--; end
    end else if (token_matches("-")) begin
      if (vcount >= 2) begin vstack[vcount-2] -= vstack[vcount-1]; vcount--; end
    end else if (token_matches("*")) begin
      if (vcount >= 2) begin vstack[vcount-2] *= vstack[vcount-1]; vcount--; end
    end else if (token_matches("/")) begin
      if (vcount >= 2 && vstack[vcount-1] != 0) begin
        vstack[vcount-2] = div_trunc(vstack[vcount-2], vstack[vcount-1]);
        vcount--;
      end
    end else if (token_matches("print")) begin
      if (vcount > 0) begin
        vcount--;
        res.kind = KIND_PRINT;
        res.value = vstack[vcount];
        hit = 1;
      end
    end else if (token_matches("char")) begin
      if (vcount > 0) begin
        vcount--;
        res.kind = KIND_CHAR;
        res.value = {24'd0, vstack[vcount][7:0]};
        hit = 1;
      end
    end else if (token_matches("dup")) begin
      if (vcount > 0 && vcount < DEPTH) begin
        vstack[vcount] = vstack[vcount-1];
        vcount++;
      end
    end else if (token_matches("drop")) begin
      if (vcount > 0) vcount--;
    end else if (token_matches("swap")) begin
      if (vcount >= 2) begin
        v = vstack[vcount-1];
        vstack[vcount-1] = vstack[vcount-2];
        vstack[vcount-2] = v;
      end
    end else if (token_matches("exit")) begin
      halted = 1;
    end
    tok_len = 0;
    return hit;
  endfunction

  task automatic predict_byte(script_byte_t b);
    emitted_t res;
    bit       got;
    got = 0;
    if (!halted) begin
      if (b.data_byte == CH_SPACE || b.data_byte == CH_TAB || b.data_byte == CH_NL)
        got = close_token(res);
      else if (tok_len < TMAX) begin
        tok_buf[tok_len] = b.data_byte;
        tok_len++;
      end
      if (b.last && !halted && !got) got = close_token(res);
    end
    if (got) expected_values.push_back(res);
    if (b.last) begin
      tok_len = 0;
      vcount = 0;
      halted = 0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%t: %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // driver: advance only once the offered byte has been transferred
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= pending_bytes[0].data_byte;
        in_ch.end_of_script <= pending_bytes[0].last;
        pending_bytes.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // monitor
  always @(posedge clk) begin
    emitted_t want;
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      want.kind = 0;
      predict_byte('{in_ch.data_byte, in_ch.end_of_script});
      bytes_sent++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      emitted_count++;
      if (expected_values.size() == 0) begin
        report("unexpected value", out_ch.out_value, '0);
      end else begin
        want = expected_values.pop_front();
        if (out_ch.out_kind !== want.kind)
          report("out_kind", 32'(out_ch.out_kind), 32'(want.kind));
        if (out_ch.out_value !== want.value)
          report("out_value", out_ch.out_value, want.value);
      end
    end
  end

  task automatic add_text(string s, bit finish_script);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back('{s[i], finish_script && i == s.len() - 1});
  endtask

  function automatic string rand_number();
    string s;
    int    n;
    s = ($urandom_range(3) == 0) ? "-" : "";
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_token();
    string ops[12];
    string s;
    ops = '{"+", "-", "*", "/", "print", "char", "dup", "drop", "swap", "exit",
            "printx", "ch"};
    case ($urandom_range(9))
      0, 1, 2, 3: return rand_number();
      4: begin
        s = "";
        for (int i = $urandom_range(1, 40); i > 0; i--)
          s = {s, string'(8'($urandom_range(255)))};
        return s;
      end
      default: return ops[$urandom_range(11)];
    endcase
  endfunction

  task automatic add_random_script();
    string sep[3];
    string s;
    int    n;
    sep = '{" ", "\t", "\n"};
    s = "";
    n = $urandom_range(2, 14);
    for (int i = 0; i < n; i++) begin
      // append one random token, which may be exit
      do s = {s, rand_token()}; while (0);
      if (i != n - 1) s = {s, sep[$urandom_range(2)]};
      if ($urandom_range(9) == 0) s = {s, sep[$urandom_range(2)]};
    end
    if ($urandom_range(3) == 0) s = {s, sep[$urandom_range(2)]};
    add_text(s, 1);
  endtask

  initial begin
    int burst;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_script = 1'b0;
    out_ch.ready = 1'b0;
    error_count = 0;
    emitted_count = 0;
    bytes_sent = 0;
    stimulus_done = 0;
    calm = 0;
    hold_off = 0;
    in_fire = 0;
    tok_len = 0;
    vcount = 0;
    halted = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed scripts: extremes, every operation, overflow, underflow, exit
    add_text("4294967295 print 0 print -2147483648 -1 / print", 1);
    add_text("7 -2 / print -7 2 / print 5 0 / print print", 1);
    add_text("3 4 + 10 - 6 * print 65 char 321 char - print", 1);
    add_text("1 2 swap print print 9 dup print print drop + swap", 1);
    add_text("-x -5abc 12\t\t3\n\nprint print", 1);
    add_text({"1 ", string'(8'h00), string'(8'hff), " 2 print exit 8 print"}, 1);
    add_text({"1234567890123456789012345678901234567 print", " 99999999999 print"}, 1);
    add_text("5 print", 1);
    // fill past the stack depth, then drain one
    begin
      string s;
      s = "";
      for (int i = 0; i < 34; i++) s = {s, "7 dup "};
      add_text({s, "print 1 2 - print"}, 1);
    end
    wait (pending_bytes.size() == 0);

    // long receiver stall while the sender keeps offering
    hold_off = 400;
    add_text("1 print 2 print 3 print 4 print 5 char 6 print 7 print", 1);

    while (bytes_sent + pending_bytes.size() < 600) begin
      if (pending_bytes.size() < 40) add_random_script();
      else @(posedge clk);
    end
    calm = 1;
    for (burst = 0; burst < 2; burst++) add_random_script();
    calm = 0;
    for (burst = 0; burst < 1; burst++) add_random_script();

    wait (pending_bytes.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (expected_values.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    stimulus_done = 1;

    $display("Ran %0d script bytes, checked %0d emitted values.", bytes_sent,
             emitted_count);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
